/* rtl/hsv_to_rgb_converter_unit_assert.svh */
// assertion macros for the hsv to rgb converter
// no dependencies; used by the top level only
`ifndef HSV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH

// property must hold on every clock edge outside reset
`define HSV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define HSV_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/hsv_pkg.sv */
// shared types and constants for the hsv to rgb converter
// no dependencies
`default_nettype none

package hsv_pkg;

    localparam int HUE_FRAC_BITS_DEF = 4;
    localparam int CHANNEL_BITS_DEF  = 8;
    localparam int QUEUE_DEPTH       = 2;

    localparam int DEG_SECTOR  = 60;
    localparam int DEG_CIRCLE  = 360;
    localparam int HUE_INT_W   = 9;
    localparam int SECTOR_IW   = 6;
    localparam int SECTOR_W    = 3;
    localparam int NUM_SECTORS = 6;

    typedef enum logic [SECTOR_W-1:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

/* rtl/hsv_to_rgb_converter_unit.sv */
// throughput: one pixel per cycle, set by the fully pipelined back end
// busy stays low as the result side never stalls and the queue drains each cycle
// reset (synchronous, active low) clears the valid flags and the queue pointers and count only
// depends on hsv_pkg, hsv_front, hsv_fifo, hsv_back and the assertion header
`default_nettype none
`include "hsv_to_rgb_converter_unit_assert.svh"

module hsv_to_rgb_converter_unit #(
    parameter int HUE_FRAC_BITS = hsv_pkg::HUE_FRAC_BITS_DEF,
    parameter int CHANNEL_BITS  = hsv_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        start,
    output logic                                             busy,
    input  wire logic [hsv_pkg::HUE_INT_W+HUE_FRAC_BITS-1:0] i_hue,
    input  wire logic [CHANNEL_BITS-1:0]                     i_saturation,
    input  wire logic [CHANNEL_BITS-1:0]                     i_brightness,
    output logic                                             o_valid,
    output logic [CHANNEL_BITS-1:0]                          o_red,
    output logic [CHANNEL_BITS-1:0]                          o_green,
    output logic [CHANNEL_BITS-1:0]                          o_blue
);

    localparam int ITEM_W = hsv_pkg::SECTOR_W + hsv_pkg::SECTOR_IW
                            + HUE_FRAC_BITS + 2 * CHANNEL_BITS;

    logic               take;
    logic               f_valid;
    logic [ITEM_W-1:0]  f_item;
    logic [ITEM_W-1:0]  q_item;
    hsv_pkg::t_q_status q_st;

    assign busy = f_valid && q_st.full;
    assign take = start && !busy;

    hsv_front #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .CHANNEL_BITS  (CHANNEL_BITS),
        .ITEM_W        (ITEM_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .i_push_ok    (!q_st.full),
        .o_valid      (f_valid),
        .o_item       (f_item)
    );

    hsv_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (hsv_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (f_valid),
        .i_data   (f_item),
        .i_pop    (!q_st.empty),
        .o_data   (q_item),
        .o_status (q_st)
    );

    hsv_back #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .CHANNEL_BITS  (CHANNEL_BITS),
        .ITEM_W        (ITEM_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!q_st.empty),
        .i_item  (q_item),
        .o_valid (o_valid),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

    `HSV_NEVER(a_queue_never_backs_up, i_clk, i_rst_n, busy, "queue backed up")
    `HSV_ASSERT(a_beat_gives_result, i_clk, i_rst_n, take |-> ##8 o_valid, "result lost")
    `HSV_ASSERT(a_result_has_beat, i_clk, i_rst_n, o_valid |-> $past(take, 8), "spurious result")

endmodule

`default_nettype wire

/* rtl/hsv_front.sv */
// front end: hue wrap, sector classification and triangle distance
// depends on hsv_pkg
`default_nettype none

module hsv_front #(
    parameter int HUE_FRAC_BITS = hsv_pkg::HUE_FRAC_BITS_DEF,
    parameter int CHANNEL_BITS  = hsv_pkg::CHANNEL_BITS_DEF,
    parameter int ITEM_W        = hsv_pkg::SECTOR_W + hsv_pkg::SECTOR_IW
                                  + HUE_FRAC_BITS + 2 * CHANNEL_BITS
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_take,
    input  wire logic [hsv_pkg::HUE_INT_W+HUE_FRAC_BITS-1:0] i_hue,
    input  wire logic [CHANNEL_BITS-1:0]                   i_saturation,
    input  wire logic [CHANNEL_BITS-1:0]                   i_brightness,
    input  wire logic                                      i_push_ok,
    output logic                                           o_valid,
    output logic [ITEM_W-1:0]                              o_item
);

    localparam int HW   = hsv_pkg::HUE_INT_W + HUE_FRAC_BITS;
    localparam int DW   = hsv_pkg::SECTOR_IW + HUE_FRAC_BITS;
    localparam int SPAN = hsv_pkg::DEG_SECTOR << HUE_FRAC_BITS;
    localparam int CIRC = hsv_pkg::DEG_CIRCLE << HUE_FRAC_BITS;

    logic                         r_fv;
    logic [ITEM_W-1:0]            r_item;
    logic [HW-1:0]                h;
    logic [HW-1:0]                h_base;
    logic [HW-1:0]                pos;
    logic [DW-1:0]                ramp;
    logic [hsv_pkg::SECTOR_W-1:0] sec;
    hsv_pkg::t_sector             sec_e;

    always_comb begin
        h      = (i_hue >= HW'(CIRC)) ? i_hue - HW'(CIRC) : i_hue;
        sec    = '0;
        h_base = '0;
        for (int k = 1; k < hsv_pkg::NUM_SECTORS; k++) begin
            if (h >= HW'(k * SPAN)) begin
                sec    = hsv_pkg::SECTOR_W'(k);
                h_base = HW'(k * SPAN);
            end
        end
        pos   = h - h_base;
        sec_e = hsv_pkg::t_sector'(sec);
        // falling half of the triangle in odd sectors
        ramp  = sec[0] ? DW'(SPAN) - pos[DW-1:0] : pos[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (i_take) begin
            r_fv <= 1'b1;
        end else if (i_push_ok) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_item <= {sec_e, ramp, i_saturation, i_brightness};
        end
    end

    assign o_valid = r_fv;
    assign o_item  = r_item;

endmodule

`default_nettype wire

/* rtl/hsv_fifo.sv */
// short register queue between front end and back end
// depends on hsv_pkg
`default_nettype none

module hsv_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = hsv_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output hsv_pkg::t_q_status    o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_cnt == CW'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_data         = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/hsv_back.sv */
// back end: chroma, intermediate component, offset and channel mapping
// depends on hsv_pkg
`default_nettype none

module hsv_back #(
    parameter int HUE_FRAC_BITS = hsv_pkg::HUE_FRAC_BITS_DEF,
    parameter int CHANNEL_BITS  = hsv_pkg::CHANNEL_BITS_DEF,
    parameter int ITEM_W        = hsv_pkg::SECTOR_W + hsv_pkg::SECTOR_IW
                                  + HUE_FRAC_BITS + 2 * CHANNEL_BITS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire logic [ITEM_W-1:0]       i_item,
    output logic                         o_valid,
    output logic [CHANNEL_BITS-1:0]      o_red,
    output logic [CHANNEL_BITS-1:0]      o_green,
    output logic [CHANNEL_BITS-1:0]      o_blue
);

    localparam int N    = CHANNEL_BITS;
    localparam int DW   = hsv_pkg::SECTOR_IW + HUE_FRAC_BITS;
    localparam int SH   = HUE_FRAC_BITS + 2;
    localparam int DIV  = hsv_pkg::DEG_SECTOR / 4;
    localparam int TW   = N + 4;
    localparam int KW   = 2 * N + 5;
    localparam int KDIV = (1 << (N + 4)) / DIV;
    localparam int FULL = (1 << N) - 1;

    hsv_pkg::t_sector  in_sec;
    logic [DW-1:0]     in_dist;
    logic [N-1:0]      in_sat;
    logic [N-1:0]      in_bri;

    logic [5:0]        r_vld;
    hsv_pkg::t_sector  r_s1, r_s2, r_s3, r_s4, r_s5;
    logic [DW-1:0]     r_d1, r_d2;
    logic [N-1:0]      r_v1, r_v2;
    logic [2*N-1:0]    r_p1;
    logic [N-1:0]      r_c2, r_c3, r_c4, r_c5;
    logic [N+DW-1:0]   r_m3;
    logic [N-1:0]      r_b3, r_b4, r_b5;
    logic [TW-1:0]     r_t4;
    logic [KW-1:0]     r_tk4;
    logic [N-1:0]      r_mid5;
    logic [N-1:0]      r_red, r_green, r_blue;

    logic [N-1:0]      q2;
    logic [N:0]        rem2;
    logic [N-1:0]      chroma;
    logic [TW-1:0]     t4;
    logic [N-1:0]      q5;
    logic [TW-1:0]     rem5;
    logic [N-1:0]      mid;
    logic [N-1:0]      n_r, n_g, n_b;

    assign {in_sec, in_dist, in_sat, in_bri} = i_item;

    // divide by full scale: high half estimate plus one correction
    assign q2     = r_p1[2*N-1:N];
    assign rem2   = {1'b0, r_p1[N-1:0]} + {1'b0, q2};
    assign chroma = q2 + N'(rem2 >= (N+1)'(FULL));

    // divide by the sector span: shift, then reciprocal of fifteen
    assign t4   = r_m3[N+DW-1:SH];
    assign q5   = r_tk4[2*N+3:N+4];
    assign rem5 = r_t4 - ((TW'(q5) << 4) - TW'(q5));
    assign mid  = q5 + N'(rem5 >= TW'(DIV));

    always_comb begin
        case (r_s5)
            hsv_pkg::SEC_RED_YEL: begin n_r = r_c5;   n_g = r_mid5; n_b = '0;     end
            hsv_pkg::SEC_YEL_GRN: begin n_r = r_mid5; n_g = r_c5;   n_b = '0;     end
            hsv_pkg::SEC_GRN_CYN: begin n_r = '0;     n_g = r_c5;   n_b = r_mid5; end
            hsv_pkg::SEC_CYN_BLU: begin n_r = '0;     n_g = r_mid5; n_b = r_c5;   end
            hsv_pkg::SEC_BLU_MAG: begin n_r = r_mid5; n_g = '0;     n_b = r_c5;   end
            default:              begin n_r = r_c5;   n_g = '0;     n_b = r_mid5; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1   <= (2*N)'(in_sat) * (2*N)'(in_bri);
        r_s1   <= in_sec;
        r_d1   <= in_dist;
        r_v1   <= in_bri;

        r_c2   <= chroma;
        r_s2   <= r_s1;
        r_d2   <= r_d1;
        r_v2   <= r_v1;

        r_m3   <= (N+DW)'(r_c2) * (N+DW)'(r_d2);
        r_b3   <= r_v2 - r_c2;
        r_c3   <= r_c2;
        r_s3   <= r_s2;

        r_t4   <= t4;
        r_tk4  <= KW'(t4) * KW'(KDIV);
        r_b4   <= r_b3;
        r_c4   <= r_c3;
        r_s4   <= r_s3;

        r_mid5 <= mid;
        r_b5   <= r_b4;
        r_c5   <= r_c4;
        r_s5   <= r_s4;

        r_red   <= n_r + r_b5;
        r_green <= n_g + r_b5;
        r_blue  <= n_b + r_b5;
    end

    assign o_valid = r_vld[5];
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

`default_nettype wire
